// File: src/fixed_block_pool_allocator_unit_defines.svh
// Assertion macros used by the checker file of the block pool allocator.
// No dependencies; included by bare file name.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fbpa_pkg.sv
// Package of the block pool allocator: pool geometry, codes and the
// interface types between the top level and the free stack. No dependencies.
package fbpa_pkg;

  localparam int unsigned NUM_BLOCKS  = 64;
  localparam int unsigned BLOCK_WORDS = 32;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned BLOCK_BYTES = BLOCK_WORDS * WORD_BYTES;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int unsigned POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
  localparam int unsigned IDX_W       = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_RELEASE = 2'd1,
    ST_EMPTY       = 2'd2
  } status_e;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] idx;
  } stk_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] top;
    logic [CNT_W-1:0] count;
  } stk_stat_t;

endpackage

// File: src/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fbpa_stack.sv
// Free stack of block indices: top entry in a register, the rest in a RAM
// with a prefetched second entry. Depends on fbpa_pkg and fbpa_ram.
module fbpa_stack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fbpa_pkg::stk_cmd_t   cmd_i,
  output fbpa_pkg::stk_stat_t  stat_o
);
  import fbpa_pkg::*;

  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_m1, rd_cnt;
  logic [IDX_W-1:0]      top_q, top_d, below;
  logic [IDX_W-1:0]      raddr_q, raddr_d, waddr;
  logic                  rvalid_q, rvalid_d;
  logic                  byp_q, byp_d;
  logic [IDX_W-1:0]      byp_data_q;
  logic [NUM_BLOCKS-1:0] wvalid_q, wvalid_d;
  logic                  we;
  logic [IDX_W-1:0]      ram_rdata;

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (top_q),
    .raddr_i (raddr_d),
    .rdata_o (ram_rdata)
  );

  // An entry never written holds its reset value, NUM_BLOCKS-1 minus its index.
  always_comb begin
    if (byp_q) begin
      below = byp_data_q;
    end else if (rvalid_q) begin
      below = ram_rdata;
    end else begin
      below = IDX_W'(NUM_BLOCKS - 1) - raddr_q;
    end

    cnt_m1 = cnt_q - CNT_W'(1);
    waddr  = cnt_m1[IDX_W-1:0];
    cnt_d  = cnt_q;
    top_d  = top_q;
    we     = 1'b0;
    if (cmd_i.pop) begin
      cnt_d = cnt_m1;
      top_d = below;
    end else if (cmd_i.push) begin
      cnt_d = cnt_q + CNT_W'(1);
      top_d = cmd_i.idx;
      we    = (cnt_q != '0);
    end

    rd_cnt  = cnt_d - CNT_W'(2);
    raddr_d = rd_cnt[IDX_W-1:0];

    wvalid_d = wvalid_q;
    if (we) begin
      wvalid_d[waddr] = 1'b1;
    end
    rvalid_d = wvalid_q[raddr_d];
    byp_d    = we && (waddr == raddr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= CNT_W'(NUM_BLOCKS);
      top_q    <= '0;
      raddr_q  <= IDX_W'(NUM_BLOCKS - 2);
      rvalid_q <= 1'b0;
      byp_q    <= 1'b0;
      wvalid_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      top_q    <= top_d;
      raddr_q  <= raddr_d;
      rvalid_q <= rvalid_d;
      byp_q    <= byp_d;
      wvalid_q <= wvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= top_q;
  end

  assign stat_o.top   = top_q;
  assign stat_o.count = cnt_q;

endmodule

// File: src/fixed_block_pool_allocator_unit.sv
// Top level of the fixed-size block pool allocator.
// Depends on fbpa_pkg and fbpa_stack.
//
// The block hands out and takes back equal-sized blocks above heap_base.
// Input channel: in_valid_i, in_stall_o, with op_i (request or release) and
// block_address_i (release only). Output channel: out_valid_o, out_stall_i,
// with status_o and granted_address_o. Every input transaction yields exactly
// one output transaction, in order.
// An accepted transaction is held in an input register; when the result
// register is free or being taken, the free stack and free bitmap are
// updated and the result is registered, to be offered from there. One
// transaction is taken per cycle unless the receiver stalls, limited by the
// single free stack update per cycle. After reset every block is free,
// block 0 is granted first and heap_base is 0; heap_base is written through
// cfg_we_i and cfg_wdata_i, which the user must do only while idle, as the
// block does not enforce it. On a receiver stall the result register holds,
// the input register fills, and in_stall_o rises until the result is taken.
module fixed_block_pool_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fbpa_pkg::STATUS_W-1:0] status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]   granted_address_o
);
  import fbpa_pkg::*;

  logic                  s1_valid_q, s1_valid_d;
  op_e                   s1_op_q;
  logic [ADDR_W-1:0]     s1_addr_q;
  logic [ADDR_W-1:0]     heap_base_q;
  logic [NUM_BLOCKS-1:0] map_q, map_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [ADDR_W-1:0]     gaddr_q, gaddr_d;
  logic                  accept, fire;
  logic [ADDR_W-1:0]     off;
  logic [IDX_W-1:0]      rel_idx;
  logic                  in_range, aligned;
  stk_cmd_t              cmd;
  stk_stat_t             stat;

  fbpa_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign off      = s1_addr_q - heap_base_q;
  assign rel_idx  = off[BLOCK_SHIFT +: IDX_W];
  assign in_range = off < ADDR_W'(POOL_BYTES);
  assign aligned  = off[BLOCK_SHIFT-1:0] == '0;

  always_comb begin
    cmd      = '0;
    status_d = ST_OK;
    gaddr_d  = '0;
    map_d    = map_q;
    unique case (s1_op_q)
      OP_REQUEST: begin
        if (stat.count == '0) begin
          status_d = ST_EMPTY;
        end else begin
          gaddr_d  = heap_base_q + (ADDR_W'(stat.top) << BLOCK_SHIFT);
          cmd.pop  = fire;
          if (fire) begin
            map_d[stat.top] = 1'b0;
          end
        end
      end
      OP_RELEASE: begin
        if (!in_range || !aligned || map_q[rel_idx] ||
            stat.count >= CNT_W'(NUM_BLOCKS)) begin
          status_d = ST_BAD_RELEASE;
        end else begin
          cmd.push = fire;
          cmd.idx  = rel_idx;
          if (fire) begin
            map_d[rel_idx] = 1'b1;
          end
        end
      end
      default: begin
        status_d = ST_BAD_RELEASE;
      end
    endcase
  end

  assign s1_valid_d  = accept || (s1_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      heap_base_q <= '0;
      map_q       <= '1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      map_q       <= map_d;
      if (cfg_we_i) begin
        heap_base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_e'(op_i);
      s1_addr_q <= block_address_i;
    end
    if (fire) begin
      status_q <= status_d;
      gaddr_q  <= gaddr_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_address_o = gaddr_q;

endmodule

// File: src/fbpa_checker.sv
// Port-level checker for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_unit_defines.svh.
`include "fixed_block_pool_allocator_unit_defines.svh"

module fbpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [fbpa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          op_i,
  input logic [fbpa_pkg::ADDR_W-1:0]   block_address_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fbpa_pkg::STATUS_W-1:0] status_o,
  input logic [fbpa_pkg::ADDR_W-1:0]   granted_address_o
);
  import fbpa_pkg::*;

  `FBPA_ASSERT_NOW(a_addr_only_on_grant, clk_i, rst_ni,
    out_valid_o && (status_o != ST_OK), granted_address_o == '0,
    "Nonzero address returned without a successful grant.")

  `FBPA_ASSERT_NOW(a_stall_from_backpressure, clk_i, rst_ni,
    in_stall_o, out_valid_o && out_stall_i,
    "Input stalled while the output side is free.")

  `FBPA_ASSERT_NEXT(a_result_follows, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) ##1 !out_valid_o, out_valid_o,
    "Accepted transaction did not produce a result in time.")

  `FBPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(granted_address_o),
    "Stalled result changed or was dropped.")

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for fixed_block_pool_allocator_unit: a directed table,
// then random bursts of requests and releases under several heap bases.
// Depends on fbpa_pkg and the allocator RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef enum {ROW_ITEM, ROW_BASE} row_kind_e;
  typedef enum {BURST_DRAIN, BURST_REFILL, BURST_MIXED} burst_e;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  typedef struct {
    row_kind_e         kind;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    status_e           status;
    logic [ADDR_W-1:0] grant;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ADDR_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                op_i;
  logic [ADDR_W-1:0]   block_address_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [ADDR_W-1:0]   granted_address_o;

  logic [IDX_W-1:0]    spare_stack [NUM_BLOCKS];
  bit                  spare_flags [NUM_BLOCKS];
  int unsigned         spare_depth;
  logic [ADDR_W-1:0]   pool_base;

  alloc_result_t       alloc_results_q [$];
  int unsigned         mismatch_count;
  int unsigned         sent_count;
  int unsigned         cycle_count;

  stim_row_t directed_rows [22] = '{
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0000, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_REQUEST, 32'hFFFF_FFFF, 1'b1, ST_OK,          32'h0000_0000},
    '{ROW_ITEM, OP_REQUEST, 32'h0000_0000, 1'b1, ST_OK,          32'h0000_0080},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0080, 1'b1, ST_OK,          32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0080, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_REQUEST, 32'h5A5A_A5A5, 1'b0, ST_OK,          32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0040, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_2000, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'hFFFF_FFFF, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'hFFFF_FF80, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_1F80, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0000, 1'b1, ST_OK,          32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0080, 1'b1, ST_OK,          32'h0},
    '{ROW_BASE, OP_REQUEST, 32'hFFFF_F000, 1'b0, ST_OK,          32'h0},
    '{ROW_ITEM, OP_REQUEST, 32'h0000_0000, 1'b0, ST_OK,          32'h0},
    '{ROW_ITEM, OP_REQUEST, 32'h0000_0000, 1'b0, ST_OK,          32'h0},
    '{ROW_ITEM, OP_REQUEST, 32'h0000_0000, 1'b0, ST_OK,          32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_0000, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'hFFFF_F000, 1'b1, ST_OK,          32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'hFFFF_EF80, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'hFFFF_F001, 1'b1, ST_BAD_RELEASE, 32'h0},
    '{ROW_ITEM, OP_RELEASE, 32'h0000_1000, 1'b1, ST_BAD_RELEASE, 32'h0}
  };

  fixed_block_pool_allocator_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .block_address_i   (block_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] slot_byte_addr(int unsigned idx);
    return pool_base + ADDR_W'(idx * BLOCK_BYTES);
  endfunction

  function automatic alloc_result_t pool_predict(op_e op, logic [ADDR_W-1:0] addr);
    alloc_result_t     res;
    logic [ADDR_W-1:0] offset;
    int unsigned       idx;
    res.status = ST_OK;
    res.addr = '0;
    if (op == OP_REQUEST) begin
      if (spare_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        spare_depth--;
        idx = spare_stack[spare_depth];
        spare_flags[idx] = 1'b0;
        res.addr = slot_byte_addr(idx);
      end
    end else begin
      offset = addr - pool_base;
      idx = offset / BLOCK_BYTES;
      if (offset >= POOL_BYTES || offset % BLOCK_BYTES != 0) begin
        res.status = ST_BAD_RELEASE;
      end else if (spare_flags[idx] || spare_depth >= NUM_BLOCKS) begin
        res.status = ST_BAD_RELEASE;
      end else begin
        spare_stack[spare_depth] = IDX_W'(idx);
        spare_depth++;
        spare_flags[idx] = 1'b1;
      end
    end
    return res;
  endfunction

  // Offers one transaction, waits for its acceptance and records the result it must cause.
  task automatic send_item(input op_e op, input logic [ADDR_W-1:0] addr, input bit typed,
                           input alloc_result_t typed_result);
    alloc_result_t res;
    while (!(sent_count >= 300 && sent_count < 450) && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    block_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    res = pool_predict(op, addr);
    alloc_results_q.push_back(typed ? typed_result : res);
  endtask

  task automatic write_heap_base(input logic [ADDR_W-1:0] base);
    in_valid_i <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_base = base;
  endtask

  task automatic pick_item(input burst_e mode, output op_e op, output logic [ADDR_W-1:0] addr);
    int unsigned roll;
    int unsigned idx;
    int unsigned req_edge;
    int unsigned held_edge;
    roll = $urandom_range(99);
    idx = $urandom_range(NUM_BLOCKS - 1);
    addr = $urandom;
    op = OP_RELEASE;
    case (mode)
      BURST_DRAIN: begin
        req_edge = 88;
        held_edge = 92;
      end
      BURST_REFILL: begin
        req_edge = 10;
        held_edge = 80;
      end
      default: begin
        req_edge = 45;
        held_edge = 80;
      end
    endcase
    if (roll < req_edge || (roll < held_edge && spare_depth == NUM_BLOCKS)) begin
      op = OP_REQUEST;
    end else if (roll < held_edge) begin
      while (spare_flags[idx]) idx = (idx + 1) % NUM_BLOCKS;
      addr = slot_byte_addr(idx);
    end else begin
      case ($urandom_range(3))
        0: begin
          if (spare_depth != 0) begin
            while (!spare_flags[idx]) idx = (idx + 1) % NUM_BLOCKS;
            addr = slot_byte_addr(idx);
          end
        end
        1: addr = slot_byte_addr(idx) + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
        2: addr = slot_byte_addr(idx) + ADDR_W'(POOL_BYTES);
        default: addr = slot_byte_addr(idx) - ADDR_W'(POOL_BYTES);
      endcase
    end
  endtask

  initial begin : stimulus
    op_e               op;
    logic [ADDR_W-1:0] addr;
    burst_e            mode;
    int unsigned       burst_left;
    logic [ADDR_W-1:0] phase_bases [6];
    alloc_result_t     typed_result;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= OP_REQUEST;
    block_address_i <= '0;
    mismatch_count = 0;
    sent_count = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      spare_stack[i] = IDX_W'(NUM_BLOCKS - 1 - i);
      spare_flags[i] = 1'b1;
    end
    spare_depth = NUM_BLOCKS;
    pool_base = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_BASE) begin
        write_heap_base(directed_rows[r].addr);
      end else begin
        typed_result = '{directed_rows[r].status, directed_rows[r].grant};
        send_item(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].typed,
                  typed_result);
      end
    end

    phase_bases[0] = 32'hFFFF_FFFF;
    phase_bases[1] = ADDR_W'($urandom) & ~ADDR_W'(BLOCK_BYTES - 1);
    phase_bases[2] = ADDR_W'($urandom);
    phase_bases[3] = 32'h0000_0000;
    phase_bases[4] = 32'hFFFF_E000;
    phase_bases[5] = 32'hFFFF_F000;
    foreach (phase_bases[p]) begin
      write_heap_base(phase_bases[p]);
      mode = BURST_DRAIN;
      burst_left = 70;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          mode = burst_e'($urandom_range(2));
          burst_left = $urandom_range(8, 60);
        end
        burst_left--;
        pick_item(mode, op, addr);
        send_item(op, addr, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && alloc_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // The receiver periodically holds off for a long stretch so that the block fills up.
  initial begin : receiver
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % 1000 >= 200 && rx_cycle % 1000 < 260) begin
        out_stall_i <= 1'b1;
      end else if (rx_cycle % 1000 >= 500 && rx_cycle % 1000 < 800) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    alloc_result_t expected;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alloc_results_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual status %0d, address %h",
                 $time, status_o, granted_address_o);
        mismatch_count++;
      end else begin
        expected = alloc_results_q.pop_front();
        if (status_o !== expected.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   expected.status, status_o);
          mismatch_count++;
        end
        if (granted_address_o !== expected.addr) begin
          $display("%0t: granted address mismatch, expected %h, actual %h", $time,
                   expected.addr, granted_address_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
